FILE: rtl/dlct_pkg.sv
package dlct_pkg;

    // Operation codes on the func field
    localparam logic [1:0] FN_TICK     = 2'd0;
    localparam logic [1:0] FN_SCHEDULE = 2'd1;
    localparam logic [1:0] FN_CANCEL   = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_EXPIRED   = 3'd0;
    localparam logic [2:0] ST_SCHEDULED = 3'd1;
    localparam logic [2:0] ST_CANCELLED = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    // Most expired entries reported for one tick
    localparam int MAX_RESULTS = 32;

    // One timeout entry as held by a cell of the list
    typedef struct packed {
        logic               valid;
        logic [7:0]         handler;
        logic [31:0]        argument;
        logic signed [16:0] delta;
    } dlct_entry_t;

    // Saturate a widened delta back into 17 bits
    function automatic logic signed [16:0] sat_delta(input logic signed [17:0] v);
        logic signed [16:0] r;
        if (v < -18'sd65536)
            r = -17'sd65536;
        else if (v > 18'sd65535)
            r = 17'sd65535;
        else
            r = v[16:0];
        return r;
    endfunction

    // Lateness of an expired entry, saturated at the 16-bit minimum
    function automatic logic signed [15:0] late_of(input logic signed [16:0] d);
        logic signed [15:0] r;
        if (d < -17'sd32768)
            r = -16'sd32768;
        else
            r = d[15:0];
        return r;
    endfunction

    // Entry is due when it is pending and its delta is zero or less
    function automatic logic is_due(input dlct_entry_t e);
        return e.valid && (e.delta[16] || (e.delta == 17'sd0));
    endfunction

endpackage

FILE: rtl/delta_list_callout_timer.sv
// Delta-list callout timer.
// Input channel (in_valid/in_ready) takes one request: func selects tick,
// schedule or cancel; handler_id, argument, delay and hold_dispatch go with it.
// Output channel (out_valid/out_ready) returns results: status, handler,
// argument, lateness, tick count and last on the final result of a request.
// Pending timeouts sit in a row of NUM_ENTRIES cells in expiry order. Tick,
// schedule and cancel rotate the whole row once past a single walk unit, one
// cell per cycle; schedule and cancel then load their result. A schedule
// into a full table answers ST_FULL without a walk. Unless hold_dispatch is
// set, a tick then reports due heads one per cycle when not stalled, up to
// 32, each shifting the row by one cell. A request is taken only while no
// walk or report is busy; a finished result held in the output register
// does not block it. When the receiver stalls, the output register holds
// its result and the block waits before loading the next one.
// Reset empties the list and clears the tick count; no clearing pass needed.
module delta_list_callout_timer
#(
    parameter int NUM_ENTRIES = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic [7:0]         handler_id,
    input  logic [31:0]        argument,
    input  logic [15:0]        delay,
    input  logic               hold_dispatch,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic [7:0]         out_handler,
    output logic [31:0]        out_argument,
    output logic signed [15:0] lateness,
    output logic [31:0]        tick_count,
    output logic               last
);

    localparam int STEP_W = $clog2(NUM_ENTRIES);
    localparam int CNT_W  = $clog2(NUM_ENTRIES + 1);
    localparam int NRES_W = $clog2(dlct_pkg::MAX_RESULTS);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_DISPATCH, S_RESP} state_t;

    state_t                state_reg;
    logic [1:0]            op_reg;
    logic [7:0]            handler_reg;
    logic [31:0]           argument_reg;
    logic signed [16:0]    t_reg;
    logic                  hold_reg;
    logic                  done_reg;
    dlct_pkg::dlct_entry_t carry_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [NRES_W-1:0]     nres_reg;
    logic [2:0]            st_reg;
    logic [31:0]           ticks_reg;

    logic                  out_valid_reg;
    logic [2:0]            status_reg;
    logic [7:0]            out_handler_reg;
    logic [31:0]           out_argument_reg;
    logic signed [15:0]    lateness_reg;
    logic [31:0]           tick_count_reg;
    logic                  last_reg;

    dlct_pkg::dlct_entry_t cell_q [NUM_ENTRIES];
    dlct_pkg::dlct_entry_t tail_in;
    dlct_pkg::dlct_entry_t walk_tail;
    dlct_pkg::dlct_entry_t carry_next;
    logic                  done_next;
    logic signed [16:0]    t_next;
    logic                  shift;
    logic                  last_step;
    logic                  out_free;
    logic                  emit;
    logic                  emit_last;
    logic                  load_out;

    assign last_step = (step_reg == STEP_W'(NUM_ENTRIES - 1));
    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = (state_reg == S_DISPATCH) && out_free && dlct_pkg::is_due(cell_q[0]);
    assign emit_last = (nres_reg == NRES_W'(dlct_pkg::MAX_RESULTS - 1)) ||
                       !dlct_pkg::is_due(cell_q[1]);
    // Output register takes a new result this cycle
    assign load_out  = emit || ((state_reg == S_RESP) && out_free);

    // Row shift control: rotate through the walk unit, or drop the head
    always_comb
    begin
        shift   = 1'b0;
        tail_in = walk_tail;
        if (state_reg == S_WALK)
            shift = 1'b1;
        else if (emit)
        begin
            shift   = 1'b1;
            tail_in = '0;
        end
    end

    // Row of list cells, head at index 0
    for (genvar i = 0; i < NUM_ENTRIES; i++)
    begin : g_cell
        dlct_pkg::dlct_entry_t d_in;
        if (i == NUM_ENTRIES - 1)
        begin : g_tail
            assign d_in = tail_in;
        end
        else
        begin : g_body
            assign d_in = cell_q[i+1];
        end
        dlct_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .d_in  (d_in),
            .q     (cell_q[i])
        );
    end

    dlct_walk u_walk
    (
        .op         (op_reg),
        .cur        (cell_q[0]),
        .nxt        (cell_q[1]),
        .carry      (carry_reg),
        .done       (done_reg),
        .t          (t_reg),
        .handler_id (handler_reg),
        .argument   (argument_reg),
        .last_step  (last_step),
        .tail       (walk_tail),
        .carry_next (carry_next),
        .done_next  (done_next),
        .t_next     (t_next)
    );

    // Sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            op_reg           <= dlct_pkg::FN_TICK;
            handler_reg      <= '0;
            argument_reg     <= '0;
            t_reg            <= '0;
            carry_reg        <= '0;
            done_reg         <= 1'b0;
            step_reg         <= '0;
            count_reg        <= '0;
            nres_reg         <= '0;
            st_reg           <= dlct_pkg::ST_EXPIRED;
            ticks_reg        <= '0;
            out_valid_reg    <= 1'b0;
            status_reg       <= dlct_pkg::ST_EXPIRED;
            out_handler_reg  <= '0;
            out_argument_reg <= '0;
            lateness_reg     <= '0;
            tick_count_reg   <= '0;
            last_reg         <= 1'b0;
            hold_reg         <= 1'b0;
        end
        else
        begin
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg       <= func;
                        handler_reg  <= handler_id;
                        argument_reg <= argument;
                        hold_reg     <= hold_dispatch;
                        done_reg     <= 1'b0;
                        step_reg     <= '0;
                        carry_reg    <= '0;
                        t_reg        <= (delay == 16'd0) ? 17'sd1 : $signed({1'b0, delay});
                        case (func)
                            dlct_pkg::FN_TICK:
                            begin
                                ticks_reg <= ticks_reg + 32'd1;
                                state_reg <= S_WALK;
                            end
                            dlct_pkg::FN_SCHEDULE:
                            begin
                                if (count_reg == CNT_W'(NUM_ENTRIES))
                                begin
                                    st_reg    <= dlct_pkg::ST_FULL;
                                    state_reg <= S_RESP;
                                end
                                else
                                    state_reg <= S_WALK;
                            end
                            dlct_pkg::FN_CANCEL:
                            begin
                                state_reg <= S_WALK;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_WALK:
                begin
                    carry_reg <= carry_next;
                    done_reg  <= done_next;
                    t_reg     <= t_next;
                    step_reg  <= step_reg + STEP_W'(1);
                    if (last_step)
                    begin
                        case (op_reg)
                            dlct_pkg::FN_TICK:
                            begin
                                nres_reg  <= '0;
                                state_reg <= hold_reg ? S_IDLE : S_DISPATCH;
                            end
                            dlct_pkg::FN_SCHEDULE:
                            begin
                                count_reg <= count_reg + CNT_W'(1);
                                st_reg    <= dlct_pkg::ST_SCHEDULED;
                                state_reg <= S_RESP;
                            end
                            default:
                            begin
                                if (done_next)
                                begin
                                    count_reg <= count_reg - CNT_W'(1);
                                    st_reg    <= dlct_pkg::ST_CANCELLED;
                                end
                                else
                                    st_reg <= dlct_pkg::ST_NOT_FOUND;
                                state_reg <= S_RESP;
                            end
                        endcase
                    end
                end
                S_DISPATCH:
                begin
                    if (!dlct_pkg::is_due(cell_q[0]))
                        state_reg <= S_IDLE;
                    else if (emit)
                    begin
                        status_reg       <= dlct_pkg::ST_EXPIRED;
                        out_handler_reg  <= cell_q[0].handler;
                        out_argument_reg <= cell_q[0].argument;
                        lateness_reg     <= dlct_pkg::late_of(cell_q[0].delta);
                        tick_count_reg   <= ticks_reg;
                        last_reg         <= emit_last;
                        count_reg        <= count_reg - CNT_W'(1);
                        nres_reg         <= nres_reg + NRES_W'(1);
                        if (emit_last)
                            state_reg <= S_IDLE;
                    end
                end
                S_RESP:
                begin
                    if (out_free)
                    begin
                        status_reg       <= st_reg;
                        out_handler_reg  <= handler_reg;
                        out_argument_reg <= argument_reg;
                        lateness_reg     <= 16'sd0;
                        tick_count_reg   <= ticks_reg;
                        last_reg         <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_handler  = out_handler_reg;
    assign out_argument = out_argument_reg;
    assign lateness     = lateness_reg;
    assign tick_count   = tick_count_reg;
    assign last         = last_reg;

endmodule

FILE: rtl/dlct_cell.sv
module dlct_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift,
    input  dlct_pkg::dlct_entry_t d_in,
    output dlct_pkg::dlct_entry_t q
);

    logic               valid_reg;
    logic [7:0]         handler_reg;
    logic [31:0]        argument_reg;
    logic signed [16:0] delta_reg;

    // Occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (shift)
            valid_reg <= d_in.valid;
    end

    // Entry payload, taken from the neighbor on each shift
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            handler_reg  <= d_in.handler;
            argument_reg <= d_in.argument;
            delta_reg    <= d_in.delta;
        end
    end

    assign q = '{valid: valid_reg, handler: handler_reg,
                 argument: argument_reg, delta: delta_reg};

endmodule

FILE: rtl/dlct_walk.sv
module dlct_walk
(
    input  logic [1:0]            op,
    input  dlct_pkg::dlct_entry_t cur,
    input  dlct_pkg::dlct_entry_t nxt,
    input  dlct_pkg::dlct_entry_t carry,
    input  logic                  done,
    input  logic signed [16:0]    t,
    input  logic [7:0]            handler_id,
    input  logic [31:0]           argument,
    input  logic                  last_step,
    output dlct_pkg::dlct_entry_t tail,
    output dlct_pkg::dlct_entry_t carry_next,
    output logic                  done_next,
    output logic signed [16:0]    t_next
);

    dlct_pkg::dlct_entry_t mod_nxt;
    logic signed [16:0]    dec_delta;

    // Decremented head delta and successor with the removed delta folded in
    always_comb
    begin
        dec_delta = dlct_pkg::sat_delta(18'(cur.delta) - 18'sd1);
        mod_nxt   = nxt;
        if (nxt.valid && cur.delta > 17'sd0)
            mod_nxt.delta = dlct_pkg::sat_delta(18'(nxt.delta) + 18'(cur.delta));
    end

    // One list element passes the walk point per cycle
    always_comb
    begin
        tail       = cur;
        carry_next = carry;
        done_next  = done;
        t_next     = t;
        case (op)
            dlct_pkg::FN_TICK:
            begin
                if (!done)
                begin
                    if (cur.valid)
                    begin
                        tail.delta = dec_delta;
                        done_next  = !dec_delta[16];
                    end
                    else
                        done_next = 1'b1;
                end
            end
            dlct_pkg::FN_SCHEDULE:
            begin
                if (done)
                begin
                    // Everything behind the insert point slips by one cell
                    tail       = carry;
                    carry_next = cur;
                end
                else if (cur.valid && cur.delta < t)
                begin
                    if (cur.delta > 17'sd0)
                        t_next = t - cur.delta;
                end
                else
                begin
                    tail       = '{valid: 1'b1, handler: handler_id,
                                   argument: argument, delta: t};
                    carry_next = cur;
                    if (cur.valid)
                        carry_next.delta = dlct_pkg::sat_delta(18'(cur.delta) - 18'(t));
                    done_next  = 1'b1;
                end
            end
            dlct_pkg::FN_CANCEL:
            begin
                if (done)
                begin
                    // Skip mode: take the element after the head
                    tail = last_step ? '0 : nxt;
                end
                else if (cur.valid && cur.handler == handler_id &&
                         cur.argument == argument)
                begin
                    tail      = last_step ? '0 : mod_nxt;
                    done_next = 1'b1;
                end
            end
            default:
            begin
                tail = cur;
            end
        endcase
    end

endmodule

FILE: rtl/dlct_check.sv
module dlct_check
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [2:0]         status,
    input logic signed [15:0] lateness,
    input logic [31:0]        tick_count,
    input logic               last
);

    // A stalled result holds its status and tick count
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(tick_count))
        else $error("result changed while stalled");

    // Only expiry reports come in runs; every other answer ends its request
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != dlct_pkg::ST_EXPIRED |-> last)
        else $error("non-expiry result without last");

    // Expired entries are never early
    a_late: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == dlct_pkg::ST_EXPIRED |-> lateness[15] || lateness == 16'sd0)
        else $error("positive lateness");

    // Status stays within the defined codes
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= dlct_pkg::ST_NOT_FOUND)
        else $error("undefined status code");

endmodule

bind delta_list_callout_timer dlct_check u_dlct_check
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .lateness   (lateness),
    .tick_count (tick_count),
    .last       (last)
);
